// File: hdl/ccl_pkg.sv
// Shared constants, codes and payload types of the C-cell pooling layer.
package ccl_pkg;

    localparam int MAX_PLANES = 8;
    localparam int MAX_C_SIZE = 16;
    localparam int MAX_S_SIZE = 32;
    localparam int MAX_KERNEL = 8;

    localparam int PLANE_W   = $clog2(MAX_PLANES);
    localparam int CIDX_W    = $clog2(MAX_C_SIZE);
    localparam int KIDX_W    = $clog2(MAX_KERNEL);
    localparam int CELL_AW   = 2 * CIDX_W;
    localparam int ACC_DEPTH = MAX_PLANES * MAX_C_SIZE * MAX_C_SIZE;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int WT_DEPTH  = MAX_KERNEL * MAX_KERNEL;
    localparam int WT_AW     = $clog2(WT_DEPTH);

    localparam int ACC_W    = 40;
    localparam int VAL_W    = 16;
    localparam int PROD_W   = 2 * VAL_W;
    localparam int RESP_W   = 16;
    localparam int ONE_FRAC = 26;

    localparam int S_REG_W  = 6;
    localparam int C_REG_W  = 5;
    localparam int R_REG_W  = 4;
    localparam int K_REG_W  = 4;
    localparam int CFG_W    = 6;
    localparam int CFG_IW   = 2;

    localparam logic [CFG_IW-1:0] CFG_S_SIZE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_C_SIZE = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RATIO  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_KERNEL = 2'd3;

    localparam logic [1:0] MODE_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_SAMPLE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]              mode;
        logic [2:0]              plane;
        logic [4:0]              row;
        logic [4:0]              col;
        logic signed [VAL_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [RESP_W-1:0] cell_response;
        logic              status;
    } out_t;

endpackage

// File: hdl/c_cell_layer_pooling.sv
// C-cell pooling layer: a small sequencer with one multiply-accumulate path and a divider.
//
// One item is worked on at a time; s_ready is high only while the sequencer is idle, and a
// finished result sits in an output register so the next item can be taken before it drains.
// Mode 0 (weight write) writes one kernel weight. Mode 1 (S sample) first scans the C grid
// for the row and column window, then updates each C-cell touched in turn; each update is
// a read, a multiply and a saturating write-back through the single accumulator RAM port
// pair. Mode 2 (read) waits on the 16-step divider that forms u/(1+u); a read of a cell
// whose sum is not positive skips the divider. Mode 3 (clear plane) sweeps the plane one
// cell a cycle. Items flagged out of range, and samples that are not positive, go straight
// to the result. After reset the accumulator RAM is swept to zero, during which no item is
// accepted; configuration writes are taken at any time and must only be made while the
// block is idle.
module c_cell_layer_pooling (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [ccl_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [ccl_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ccl_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ccl_pkg::out_t                m_data
);

    localparam int SW = 11;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PREP, ST_SCAN, ST_PLAN, ST_RD, ST_MUL, ST_ACC,
        ST_LOOK, ST_CHECK, ST_DIV, ST_WIPE, ST_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [ccl_pkg::S_REG_W-1:0] s_size_reg;
    logic [ccl_pkg::C_REG_W-1:0] c_size_reg;
    logic [ccl_pkg::R_REG_W-1:0] ratio_reg;
    logic [ccl_pkg::K_REG_W-1:0] kernel_reg;

    ccl_pkg::in_t                item_reg;
    logic [ccl_pkg::RESP_W-1:0]  resp_reg;
    logic                        stat_reg;
    logic                        m_valid_reg;
    ccl_pkg::out_t               m_data_reg;
    logic [ccl_pkg::ACC_AW-1:0]  cnt_reg;

    logic signed [SW-1:0]        d0_reg;
    logic signed [SW-1:0]        x_reg;
    logic [ccl_pkg::CIDX_W-1:0]  c_reg;
    logic [7:0]                  cm_reg;
    logic [ccl_pkg::CIDX_W-1:0]  rf_reg, rl_reg, cf_reg, cl_reg;
    logic [ccl_pkg::KIDX_W-1:0]  rt_reg, ct_reg;
    logic                        rfound_reg, cfound_reg;
    logic [ccl_pkg::CIDX_W-1:0]  ic_reg, jc_reg;
    logic [ccl_pkg::KIDX_W-1:0]  ia_reg, ja_reg;
    logic signed [ccl_pkg::PROD_W-1:0] prod_reg;

    // effective sizes
    logic [ccl_pkg::S_REG_W-1:0] ns;
    logic [ccl_pkg::C_REG_W-1:0] nc;
    logic [ccl_pkg::K_REG_W-1:0] nd;
    logic [ccl_pkg::R_REG_W-1:0] mc;
    logic [ccl_pkg::C_REG_W-1:0] nc_m1;
    logic [ccl_pkg::S_REG_W-1:0] ns_m1;
    logic [ccl_pkg::K_REG_W-1:0] nd_m1;
    logic [ccl_pkg::CIDX_W-1:0]  nc2;
    logic [ccl_pkg::KIDX_W-1:0]  nd2;
    logic [7:0]                  nm;
    logic signed [SW-1:0]        t_s, t_r, d0_s;

    always_comb begin
        ns = (s_size_reg == '0) ? ccl_pkg::S_REG_W'(1) :
             (s_size_reg > ccl_pkg::S_REG_W'(ccl_pkg::MAX_S_SIZE)) ?
             ccl_pkg::S_REG_W'(ccl_pkg::MAX_S_SIZE) : s_size_reg;
        nc = (c_size_reg == '0) ? ccl_pkg::C_REG_W'(1) :
             (c_size_reg > ccl_pkg::C_REG_W'(ccl_pkg::MAX_C_SIZE)) ?
             ccl_pkg::C_REG_W'(ccl_pkg::MAX_C_SIZE) : c_size_reg;
        nd = (kernel_reg == '0) ? ccl_pkg::K_REG_W'(1) :
             (kernel_reg > ccl_pkg::K_REG_W'(ccl_pkg::MAX_KERNEL)) ?
             ccl_pkg::K_REG_W'(ccl_pkg::MAX_KERNEL) : kernel_reg;
        mc = (ratio_reg == '0) ? ccl_pkg::R_REG_W'(1) : ratio_reg;
        nc_m1 = nc - 1'b1;
        ns_m1 = ns - 1'b1;
        nd_m1 = nd - 1'b1;
        nc2   = nc_m1[ccl_pkg::CIDX_W-1:0];
        nd2   = nd_m1[ccl_pkg::KIDX_W-1:0];
        nm    = 8'(nc2) * 8'(mc);
        t_s   = $signed(SW'(nm)) - $signed(SW'(ns_m1)) + $signed(SW'(nd2));
        // halve toward zero
        t_r   = t_s + $signed(SW'(t_s[SW-1]));
        d0_s  = t_r >>> 1;
    end

    // window scan: C index c is fed by S index s when its tap s+d0-c*mc lies in the kernel
    // and the mirrored lower bound (nc2-c)*mc <= ns2-s+d0 holds
    logic signed [SW-1:0] cm_s, pr, pc, lr, lc;
    logic                 vr, vc;
    logic signed [SW-1:0] tr_s, tc_s;

    always_comb begin
        cm_s = $signed(SW'(cm_reg));
        pr   = $signed(SW'(item_reg.row)) + d0_reg;
        pc   = $signed(SW'(item_reg.col)) + d0_reg;
        lr   = x_reg + $signed(SW'(item_reg.row)) - d0_reg;
        lc   = x_reg + $signed(SW'(item_reg.col)) - d0_reg;
        vr   = (cm_s <= pr) && (cm_s >= pr - $signed(SW'(nd2))) && (cm_s >= lr);
        vc   = (cm_s <= pc) && (cm_s >= pc - $signed(SW'(nd2))) && (cm_s >= lc);
        tr_s = pr - cm_s;
        tc_s = pc - cm_s;
    end

    // input range checks
    logic in_bad;
    always_comb begin
        case (s_data.mode)
            ccl_pkg::MODE_WEIGHT: in_bad = (s_data.row >= 5'(nd)) || (s_data.col >= 5'(nd));
            ccl_pkg::MODE_SAMPLE: in_bad = (32'(s_data.plane) >= ccl_pkg::MAX_PLANES) ||
                                           ({1'b0, s_data.row} >= ns) ||
                                           ({1'b0, s_data.col} >= ns);
            ccl_pkg::MODE_READ:   in_bad = (32'(s_data.plane) >= ccl_pkg::MAX_PLANES) ||
                                           (s_data.row >= nc) || (s_data.col >= nc);
            default:              in_bad = 32'(s_data.plane) >= ccl_pkg::MAX_PLANES;
        endcase
    end

    // memories
    logic                               acc_we;
    logic [ccl_pkg::ACC_AW-1:0]         acc_waddr, acc_raddr, cell_addr, rd_addr;
    logic [ccl_pkg::ACC_W-1:0]          acc_wdata, acc_rdata;
    logic                               wt_we;
    logic [ccl_pkg::WT_AW-1:0]          wt_waddr, wt_raddr;
    logic [ccl_pkg::VAL_W-1:0]          wt_rdata;
    logic signed [ccl_pkg::ACC_W:0]     sum;
    logic signed [ccl_pkg::ACC_W-1:0]   sum_sat;
    logic signed [ccl_pkg::ACC_W-1:0]   acc_s;

    localparam logic signed [ccl_pkg::ACC_W:0] ACC_MAX =
        $signed({2'b00, {(ccl_pkg::ACC_W-1){1'b1}}});
    localparam logic signed [ccl_pkg::ACC_W:0] ACC_MIN =
        $signed({2'b11, {(ccl_pkg::ACC_W-1){1'b0}}});

    always_comb begin
        acc_s     = $signed(acc_rdata);
        sum       = $signed({acc_s[ccl_pkg::ACC_W-1], acc_s}) +
                    $signed((ccl_pkg::ACC_W+1)'(prod_reg));
        sum_sat   = (sum > ACC_MAX) ? ACC_MAX[ccl_pkg::ACC_W-1:0] :
                    (sum < ACC_MIN) ? ACC_MIN[ccl_pkg::ACC_W-1:0] :
                    sum[ccl_pkg::ACC_W-1:0];
        cell_addr = {item_reg.plane, ic_reg, jc_reg};
        rd_addr   = {item_reg.plane, item_reg.row[ccl_pkg::CIDX_W-1:0],
                     item_reg.col[ccl_pkg::CIDX_W-1:0]};
        acc_raddr = (item_reg.mode == ccl_pkg::MODE_READ) ? rd_addr : cell_addr;
        acc_we    = 1'b0;
        acc_waddr = cnt_reg;
        acc_wdata = '0;
        case (state_reg)
            ST_CLEAR: acc_we = 1'b1;
            ST_WIPE: begin
                acc_we    = 1'b1;
                acc_waddr = {item_reg.plane, cnt_reg[ccl_pkg::CELL_AW-1:0]};
            end
            ST_ACC: begin
                acc_we    = 1'b1;
                acc_waddr = cell_addr;
                acc_wdata = sum_sat;
            end
            default: acc_we = 1'b0;
        endcase
        wt_we    = s_valid && s_ready && (s_data.mode == ccl_pkg::MODE_WEIGHT) && !in_bad;
        wt_waddr = {s_data.row[ccl_pkg::KIDX_W-1:0], s_data.col[ccl_pkg::KIDX_W-1:0]};
        wt_raddr = {ia_reg, ja_reg};
    end

    ccl_ram #(.WIDTH(ccl_pkg::ACC_W), .DEPTH(ccl_pkg::ACC_DEPTH)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    ccl_ram #(.WIDTH(ccl_pkg::VAL_W), .DEPTH(ccl_pkg::WT_DEPTH)) u_wt_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (s_data.value),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    logic                       div_start, div_done;
    logic [ccl_pkg::RESP_W-1:0] div_quot;

    assign div_start = (state_reg == ST_CHECK) && (acc_s > 0);

    ccl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .u       (acc_rdata[ccl_pkg::ACC_W-2:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            s_size_reg  <= ccl_pkg::S_REG_W'(16);
            c_size_reg  <= ccl_pkg::C_REG_W'(8);
            ratio_reg   <= ccl_pkg::R_REG_W'(2);
            kernel_reg  <= ccl_pkg::K_REG_W'(5);
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ccl_pkg::CFG_S_SIZE: s_size_reg <= cfg_wdata;
                    ccl_pkg::CFG_C_SIZE: c_size_reg <= cfg_wdata[ccl_pkg::C_REG_W-1:0];
                    ccl_pkg::CFG_RATIO:  ratio_reg  <= cfg_wdata[ccl_pkg::R_REG_W-1:0];
                    default:             kernel_reg <= cfg_wdata[ccl_pkg::K_REG_W-1:0];
                endcase
            end
            // in ST_DONE the output register is reloaded instead
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ccl_pkg::ACC_AW'(ccl_pkg::ACC_DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg <= s_data;
                        resp_reg <= '0;
                        stat_reg <= in_bad;
                        cnt_reg  <= '0;
                        if (in_bad) begin
                            state_reg <= ST_DONE;
                        end else begin
                            case (s_data.mode)
                                ccl_pkg::MODE_SAMPLE:
                                    state_reg <= (s_data.value > 0) ? ST_PREP : ST_DONE;
                                ccl_pkg::MODE_READ:  state_reg <= ST_LOOK;
                                ccl_pkg::MODE_CLEAR: state_reg <= ST_WIPE;
                                default:             state_reg <= ST_DONE;
                            endcase
                        end
                    end
                end
                ST_PREP: begin
                    d0_reg     <= d0_s;
                    x_reg      <= $signed(SW'(nm)) - $signed(SW'(ns_m1));
                    c_reg      <= '0;
                    cm_reg     <= '0;
                    rfound_reg <= 1'b0;
                    cfound_reg <= 1'b0;
                    state_reg  <= ST_SCAN;
                end
                ST_SCAN: begin
                    // walk the C grid once, recording first and last hit and first tap
                    if (vr) begin
                        if (!rfound_reg) begin
                            rf_reg <= c_reg;
                            rt_reg <= tr_s[ccl_pkg::KIDX_W-1:0];
                        end
                        rl_reg     <= c_reg;
                        rfound_reg <= 1'b1;
                    end
                    if (vc) begin
                        if (!cfound_reg) begin
                            cf_reg <= c_reg;
                            ct_reg <= tc_s[ccl_pkg::KIDX_W-1:0];
                        end
                        cl_reg     <= c_reg;
                        cfound_reg <= 1'b1;
                    end
                    c_reg  <= c_reg + 1'b1;
                    cm_reg <= cm_reg + 8'(mc);
                    if (c_reg == nc2) begin
                        state_reg <= ST_PLAN;
                    end
                end
                ST_PLAN: begin
                    ic_reg    <= rf_reg;
                    jc_reg    <= cf_reg;
                    ia_reg    <= rt_reg;
                    ja_reg    <= ct_reg;
                    state_reg <= (rfound_reg && cfound_reg) ? ST_RD : ST_DONE;
                end
                ST_RD: begin
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= $signed(wt_rdata) * item_reg.value;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    // advance along the row, then to the next row of the window
                    state_reg <= ST_RD;
                    if (jc_reg == cl_reg) begin
                        jc_reg <= cf_reg;
                        ja_reg <= ct_reg;
                        if (ic_reg == rl_reg) begin
                            state_reg <= ST_DONE;
                        end else begin
                            ic_reg <= ic_reg + 1'b1;
                            ia_reg <= ia_reg - mc[ccl_pkg::KIDX_W-1:0];
                        end
                    end else begin
                        jc_reg <= jc_reg + 1'b1;
                        ja_reg <= ja_reg - mc[ccl_pkg::KIDX_W-1:0];
                    end
                end
                ST_LOOK: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    state_reg <= (acc_s > 0) ? ST_DIV : ST_DONE;
                end
                ST_DIV: begin
                    if (div_done) begin
                        resp_reg  <= div_quot;
                        state_reg <= ST_DONE;
                    end
                end
                ST_WIPE: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[ccl_pkg::CELL_AW-1:0] == '1) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.cell_response <= resp_reg;
                        m_data_reg.status        <= stat_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/ccl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/ccl_div.sv
// Restoring divider for the squashing function u / (1 + u), one quotient bit a cycle.
module ccl_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ccl_pkg::ACC_W-2:0]     u,
    output logic                          done,
    output logic [ccl_pkg::RESP_W-1:0]    quot
);

    localparam int CNT_W = $clog2(ccl_pkg::RESP_W);

    logic [ccl_pkg::ACC_W-1:0] den_reg;
    logic [ccl_pkg::ACC_W-1:0] rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic [ccl_pkg::ACC_W:0]   shifted;
    logic                      fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                // remainder starts at u, which is always below u + 1.0
                den_reg  <= {1'b0, u} + (ccl_pkg::ACC_W)'(1) * (2 ** ccl_pkg::ONE_FRAC);
                rem_reg  <= {1'b0, u};
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= ccl_pkg::ACC_W'(shifted - {1'b0, den_reg});
                end else begin
                    rem_reg <= shifted[ccl_pkg::ACC_W-1:0];
                end
                quot    <= {quot[ccl_pkg::RESP_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ccl_pkg::RESP_W - 1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

// File: tb/ccl_pooling_checker.sv
// Checker for the C-cell pooling layer: tracks registers, predicts each result, compares.
`timescale 1ns / 100ps

module ccl_pooling_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [ccl_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ccl_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  ccl_pkg::in_t                s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  ccl_pkg::out_t               m_data,
    output int                          fail_count,
    output int                          pending
);

    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -SAT_HI - 1;

    logic signed [ccl_pkg::VAL_W-1:0] kernel_weight [ccl_pkg::WT_DEPTH];
    longint                           cell_sum [ccl_pkg::ACC_DEPTH];
    logic [ccl_pkg::S_REG_W-1:0]      s_size;
    logic [ccl_pkg::C_REG_W-1:0]      c_size;
    logic [ccl_pkg::R_REG_W-1:0]      ratio;
    logic [ccl_pkg::K_REG_W-1:0]      k_size;
    ccl_pkg::out_t                    expected_q [$];

    function automatic int clamp_sz(int v, int mx);
        if (v < 1) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic int floor_div(int a, int m);
        int q;
        q = a / m;
        if (a % m != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic int window_hi(int s, int d0, int mc, int nc2);
        int q;
        q = floor_div(s + d0, mc);
        return (q > nc2) ? nc2 : q;
    endfunction

    // Spread one positive sample into every C-cell whose window holds it.
    function automatic void spread_sample(int pl, int r, int c, int sample);
        int ns2, nc2, nd2, mc, d0, rlo, rhi, clo, chi, ra0, ca0, ia, ja, idx;
        longint acc;
        ns2 = clamp_sz(s_size, ccl_pkg::MAX_S_SIZE) - 1;
        nc2 = clamp_sz(c_size, ccl_pkg::MAX_C_SIZE) - 1;
        nd2 = clamp_sz(k_size, ccl_pkg::MAX_KERNEL) - 1;
        mc  = (ratio < 1) ? 1 : int'(ratio);
        d0  = (nc2 * mc - ns2 + nd2) / 2;
        rhi = window_hi(r, d0, mc, nc2);
        rlo = nc2 - window_hi(ns2 - r, d0, mc, nc2);
        chi = window_hi(c, d0, mc, nc2);
        clo = nc2 - window_hi(ns2 - c, d0, mc, nc2);
        ra0 = r - rlo * mc + d0;
        ca0 = c - clo * mc + d0;
        for (int ic = rlo; ic <= rhi; ic++) begin
            ia = ra0 - (ic - rlo) * mc;
            if (ic < 0 || ic > nc2 || ia < 0 || ia > nd2) continue;
            for (int jc = clo; jc <= chi; jc++) begin
                ja = ca0 - (jc - clo) * mc;
                if (jc < 0 || jc > nc2 || ja < 0 || ja > nd2) continue;
                idx = (pl * ccl_pkg::MAX_C_SIZE + ic) * ccl_pkg::MAX_C_SIZE + jc;
                acc = cell_sum[idx] +
                      longint'(kernel_weight[ia * ccl_pkg::MAX_KERNEL + ja]) * sample;
                if (acc > SAT_HI) acc = SAT_HI;
                if (acc < SAT_LO) acc = SAT_LO;
                cell_sum[idx] = acc;
            end
        end
    endfunction

    function automatic ccl_pkg::out_t pool_step(ccl_pkg::in_t it);
        ccl_pkg::out_t res;
        int nd, ns, nc, r, c, pl;
        longint u;
        longint unsigned num, den;
        res = '0;
        r   = it.row;
        c   = it.col;
        pl  = it.plane;
        case (it.mode)
            ccl_pkg::MODE_WEIGHT: begin
                nd = clamp_sz(k_size, ccl_pkg::MAX_KERNEL);
                if (r >= nd || c >= nd) res.status = 1'b1;
                else kernel_weight[r * ccl_pkg::MAX_KERNEL + c] = it.value;
            end
            ccl_pkg::MODE_SAMPLE: begin
                ns = clamp_sz(s_size, ccl_pkg::MAX_S_SIZE);
                if (pl >= ccl_pkg::MAX_PLANES || r >= ns || c >= ns) res.status = 1'b1;
                else if (it.value > 0) spread_sample(pl, r, c, it.value);
            end
            ccl_pkg::MODE_READ: begin
                nc = clamp_sz(c_size, ccl_pkg::MAX_C_SIZE);
                if (pl >= ccl_pkg::MAX_PLANES || r >= nc || c >= nc) begin
                    res.status = 1'b1;
                end else begin
                    u = cell_sum[(pl * ccl_pkg::MAX_C_SIZE + r) * ccl_pkg::MAX_C_SIZE + c];
                    if (u > 0) begin
                        num = longint'(u) << 16;
                        den = longint'(u) + (64'd1 << ccl_pkg::ONE_FRAC);
                        res.cell_response = ccl_pkg::RESP_W'(num / den);
                    end
                end
            end
            default: begin
                if (pl >= ccl_pkg::MAX_PLANES) res.status = 1'b1;
                else for (int i = 0; i < ccl_pkg::MAX_C_SIZE * ccl_pkg::MAX_C_SIZE; i++)
                    cell_sum[pl * ccl_pkg::MAX_C_SIZE * ccl_pkg::MAX_C_SIZE + i] = 0;
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        ccl_pkg::out_t want;
        if (!aresetn) begin
            for (int i = 0; i < ccl_pkg::ACC_DEPTH; i++) cell_sum[i] = 0;
            for (int i = 0; i < ccl_pkg::WT_DEPTH; i++) kernel_weight[i] = '0;
            s_size = 6'd16;
            c_size = 5'd8;
            ratio  = 4'd2;
            k_size = 4'd5;
            expected_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ccl_pkg::CFG_S_SIZE: s_size = cfg_wdata[ccl_pkg::S_REG_W-1:0];
                    ccl_pkg::CFG_C_SIZE: c_size = cfg_wdata[ccl_pkg::C_REG_W-1:0];
                    ccl_pkg::CFG_RATIO:  ratio  = cfg_wdata[ccl_pkg::R_REG_W-1:0];
                    default:             k_size = cfg_wdata[ccl_pkg::K_REG_W-1:0];
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: response %h status %b",
                                 m_data.cell_response, m_data.status);
                end else begin
                    want = expected_q.pop_front();
                    if (want.cell_response !== m_data.cell_response
                        || want.status !== m_data.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result wrong: expected %h/%b got %h/%b",
                                     want.cell_response, want.status,
                                     m_data.cell_response, m_data.status);
                    end
                end
            end
            if (s_valid && s_ready) expected_q.push_back(pool_step(s_data));
        end
        pending = expected_q.size();
    end

endmodule

// File: tb/c_cell_layer_pooling_tb.sv
// Testbench top of the C-cell pooling layer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module c_cell_layer_pooling_tb;

    localparam int CYCLE_LIMIT = 4000000;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [ccl_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [ccl_pkg::CFG_W-1:0]    cfg_wdata = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    ccl_pkg::in_t                 s_data = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    ccl_pkg::out_t                m_data;
    int                           fail_count;
    int                           pending;
    int                           cycles = 0;
    int                           send_idle = 38;   // percent of cycles the sender holds off
    int                           recv_idle = 53;   // percent of cycles the receiver stalls
    // Shadow of the sizes, used only to aim indices near the configured edges.
    int                           sh_s = 16, sh_c = 8, sh_k = 5;

    c_cell_layer_pooling DUT (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data
    );

    ccl_pooling_checker checker_i (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random, decided each falling edge.
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("c_cell_layer_pooling: mismatch");
            $finish;
        end
    end

    // Offer one item, with random hold-off first; return at the falling edge after it is taken.
    task automatic send(input ccl_pkg::in_t it);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [1:0] md, input int pl, input int r, input int c,
                               input int v);
        ccl_pkg::in_t it;
        it.mode  = md;
        it.plane = 3'(pl);
        it.row   = 5'(r);
        it.col   = 5'(c);
        it.value = 16'(v);
        send(it);
    endtask

    // Drain the block, give the pipeline a few spare cycles, then write a register.
    task automatic write_reg(input logic [ccl_pkg::CFG_IW-1:0] idx, input int v);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= ccl_pkg::CFG_W'(v);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            ccl_pkg::CFG_S_SIZE: sh_s = (v % 64 < 1) ? 1 :
                ((v % 64 > ccl_pkg::MAX_S_SIZE) ? ccl_pkg::MAX_S_SIZE : v % 64);
            ccl_pkg::CFG_C_SIZE: sh_c = (v % 32 < 1) ? 1 :
                ((v % 32 > ccl_pkg::MAX_C_SIZE) ? ccl_pkg::MAX_C_SIZE : v % 32);
            ccl_pkg::CFG_KERNEL: sh_k = (v % 16 < 1) ? 1 :
                ((v % 16 > ccl_pkg::MAX_KERNEL) ? ccl_pkg::MAX_KERNEL : v % 16);
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int s, input int c, input int r, input int k);
        write_reg(ccl_pkg::CFG_S_SIZE, s);
        write_reg(ccl_pkg::CFG_C_SIZE, c);
        write_reg(ccl_pkg::CFG_RATIO, r);
        write_reg(ccl_pkg::CFG_KERNEL, k);
    endtask

    // Pick an index: mostly inside the configured edge, sometimes anywhere in the field.
    function automatic int pick_idx(int lim);
        if ($urandom_range(99) < 85) return $urandom_range(lim - 1);
        return $urandom_range(31);
    endfunction

    function automatic ccl_pkg::in_t random_item();
        ccl_pkg::in_t it;
        int           pick;
        it       = '0;
        it.plane = 3'($urandom_range(7));
        it.value = 16'($urandom);
        pick     = $urandom_range(99);
        if (pick < 25) begin
            it.mode = ccl_pkg::MODE_WEIGHT;
            it.row  = 5'(pick_idx(sh_k));
            it.col  = 5'(pick_idx(sh_k));
        end else if (pick < 70) begin
            it.mode = ccl_pkg::MODE_SAMPLE;
            it.row  = 5'(pick_idx(sh_s));
            it.col  = 5'(pick_idx(sh_s));
            // Favor positive samples: only those reach the accumulators.
            if ($urandom_range(99) < 75) it.value = 16'($urandom_range(1, 32767));
        end else if (pick < 95) begin
            it.mode = ccl_pkg::MODE_READ;
            it.row  = 5'(pick_idx(sh_c));
            it.col  = 5'(pick_idx(sh_c));
        end else begin
            it.mode = ccl_pkg::MODE_CLEAR;
            it.row  = 5'($urandom_range(31));
            it.col  = 5'($urandom_range(31));
        end
        return it;
    endfunction

    initial begin
        int seg_s [6] = '{1, 32, 63, 0, 16, 0};
        int seg_c [6] = '{1, 16, 31, 0, 8, 0};
        int seg_r [6] = '{1, 8, 15, 0, 2, 0};
        int seg_k [6] = '{1, 8, 15, 0, 5, 0};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Hold off until the clearing sweep after reset is over.
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);

        // Fill the whole kernel so no later sample ever reads an unwritten weight.
        write_reg(ccl_pkg::CFG_KERNEL, 8);
        send_fields(ccl_pkg::MODE_WEIGHT, 0, 0, 0, 32767);
        send_fields(ccl_pkg::MODE_WEIGHT, 5, 0, 1, -32768);
        for (int i = 2; i < ccl_pkg::WT_DEPTH; i++)
            send_fields(ccl_pkg::MODE_WEIGHT, 0, i / ccl_pkg::MAX_KERNEL,
                        i % ccl_pkg::MAX_KERNEL, $urandom);

        // Directed: out-of-range indices, sample signs and sizes, reads, clears.
        send_fields(ccl_pkg::MODE_WEIGHT, 0, 8, 0, 100);
        send_fields(ccl_pkg::MODE_WEIGHT, 0, 0, 31, 100);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 0, 0, 32767);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 15, 15, 32767);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 7, 8, 1);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 16, 0, 500);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 0, 31, 500);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 3, 3, 0);
        send_fields(ccl_pkg::MODE_SAMPLE, 0, 3, 3, -32768);
        send_fields(ccl_pkg::MODE_READ, 0, 0, 0, 0);
        send_fields(ccl_pkg::MODE_READ, 0, 7, 7, 0);
        send_fields(ccl_pkg::MODE_READ, 0, 3, 4, 0);
        send_fields(ccl_pkg::MODE_READ, 0, 8, 0, 0);
        send_fields(ccl_pkg::MODE_READ, 0, 0, 31, 0);
        send_fields(ccl_pkg::MODE_SAMPLE, 7, 5, 5, 1000);
        send_fields(ccl_pkg::MODE_READ, 7, 2, 2, 0);
        send_fields(ccl_pkg::MODE_CLEAR, 7, 31, 31, -1);
        send_fields(ccl_pkg::MODE_READ, 7, 2, 2, 0);

        // Random segments over several register settings and idle patterns.
        seg_s[5] = $urandom_range(63);
        seg_c[5] = $urandom_range(31);
        seg_r[5] = $urandom_range(15);
        seg_k[5] = $urandom_range(15);
        for (int seg = 0; seg < 6; seg++) begin
            set_sizes(seg_s[seg], seg_c[seg], seg_r[seg], seg_k[seg]);
            if (seg < 2) begin
                send_idle = 38;
                recv_idle = 53;
            end else if (seg < 4) begin
                send_idle = 53;
                recv_idle = 38;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            repeat (85) send(random_item());
        end

        // Drain and let the output register settle before the verdict.
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (fail_count == 0) begin
            $display("c_cell_layer_pooling: match");
        end else begin
            $display("c_cell_layer_pooling: mismatch");
        end
        $finish;
    end

endmodule
